[src/mgte_pkg.sv]
// Package for the matrix graph traversal engine: widths, codes and states.
`default_nettype none
package mgte_pkg;

  localparam int VTX_W = 4;
  localparam int WGT_W = 16;
  localparam int ECNT_W = 9;
  localparam int DEG_W = 5;
  localparam int CFG_W = 5;
  localparam int MODE_W = 3;

  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_WEIGHT_BITS = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [MODE_W-1:0] MODE_SET  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DEL  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DFS  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BFS  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TOPO = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_DFS,
    ST_BFS,
    ST_TNEXT,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

[src/matrix_graph_traversal_engine.sv]
// Adjacency-matrix graph store with edge updates and DFS, BFS and topological walks.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  input   | in_mode, in_from_vertex, in_to_vertex,  | taken when start && !busy
//          | in_edge_weight                          |
//  result  | out_visited_vertex, out_read_weight,    | one word per out_strobe cycle
//          | out_edge_total, out_dest_in_degree,     |
//          | out_status, out_last                    |
//  config  | cfg_we, cfg_wdata                       | written when cfg_we is high
//
// Set and delete answer in the next cycle without going busy; a read goes busy through ST_RD.
// A walk scans one matrix entry per cycle through a single edge-test step, then emits
// one vertex word per cycle.
// Reset clears the edge valid bits, degrees and counter at once; no clearing pass.
// The receiver cannot stall: every result word is shown for exactly one cycle.
`default_nettype none
module matrix_graph_traversal_engine
  import mgte_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [MODE_W-1:0]        in_mode,
  input  wire logic [VTX_W-1:0]         in_from_vertex,
  input  wire logic [VTX_W-1:0]         in_to_vertex,
  input  wire logic signed [WGT_W-1:0]  in_edge_weight,
  output logic                          out_strobe,
  output logic [VTX_W-1:0]              out_visited_vertex,
  output logic signed [WGT_W-1:0]       out_read_weight,
  output logic [ECNT_W-1:0]             out_edge_total,
  output logic [DEG_W-1:0]              out_dest_in_degree,
  output logic                          out_status,
  output logic                          out_last,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_W-1:0]         cfg_wdata
);

  localparam int VCAP = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
  localparam int IW = $clog2(VCAP);
  localparam int CW = $clog2(VCAP + 1);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] cfg_r;
  logic [VCAP-1:0]  vld_r [VCAP];
  logic [VCAP-1:0]  vld_nxt [VCAP];
  logic [WEIGHT_BITS-1:0] mem_r [VCAP][VCAP];
  logic [WEIGHT_BITS-1:0] rdata_r;
  logic             mem_we;
  logic [DEG_W-1:0] deg_r [VCAP];
  logic [DEG_W-1:0] deg_nxt [VCAP];
  logic [ECNT_W-1:0] ecnt_r, ecnt_nxt;
  logic [VCAP-1:0]  vis_r, vis_nxt;
  logic [VTX_W-1:0] stk_r [VCAP];
  logic [VTX_W-1:0] stk_nxt [VCAP];
  logic [CW-1:0]    cur_r [VCAP];
  logic [CW-1:0]    cur_nxt [VCAP];
  logic [VTX_W-1:0] lst_r [VCAP];
  logic [VTX_W-1:0] lst_nxt [VCAP];
  logic [CW-1:0]    sp_r, sp_nxt;
  logic [CW-1:0]    w_r, w_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  logic             post_r, post_nxt;
  logic             hit_r, hit_nxt;
  logic [IW-1:0]    t_r, t_nxt;

  logic                    strobe_r, strobe_nxt;
  logic [VTX_W-1:0]        vv_r, vv_nxt;
  logic signed [WGT_W-1:0] rw_r, rw_nxt;
  logic [ECNT_W-1:0]       et_r, et_nxt;
  logic [DEG_W-1:0]        dd_r, dd_nxt;
  logic                    st_r, st_nxt;
  logic                    la_r, la_nxt;

  logic [CW-1:0]    n_cnt;
  logic [IW-1:0]    fi, ti, wi, top_idx, vi, bi;
  logic signed [WEIGHT_BITS-1:0] wst;
  logic             in_ok, from_ok, exists, w_lt;
  logic [CW-1:0]    sp_m1, sp_m2, e_idx;
  logic [VTX_W-1:0] v_top, v_bfs;

  always_comb begin
    if (cfg_r == '0) begin
      n_cnt = CW'(1);
    end else if (cfg_r > CFG_W'(VCAP)) begin
      n_cnt = CW'(VCAP);
    end else begin
      n_cnt = cfg_r[CW-1:0];
    end
  end

  assign fi = in_from_vertex[IW-1:0];
  assign ti = in_to_vertex[IW-1:0];
  assign wst = WEIGHT_BITS'(in_edge_weight);
  assign from_ok = CFG_W'(in_from_vertex) < CFG_W'(n_cnt);
  assign in_ok = from_ok && (CFG_W'(in_to_vertex) < CFG_W'(n_cnt));
  assign exists = vld_r[fi][ti];
  assign sp_m1 = sp_r - CW'(1);
  assign sp_m2 = sp_r - CW'(2);
  assign top_idx = sp_m1[IW-1:0];
  assign v_top = stk_r[top_idx];
  assign v_bfs = lst_r[head_r[IW-1:0]];
  assign vi = v_top[IW-1:0];
  assign bi = v_bfs[IW-1:0];
  assign wi = w_r[IW-1:0];
  assign w_lt = w_r < n_cnt;

  always_comb begin
    state_nxt = state_r;
    vld_nxt = vld_r;
    deg_nxt = deg_r;
    ecnt_nxt = ecnt_r;
    vis_nxt = vis_r;
    stk_nxt = stk_r;
    cur_nxt = cur_r;
    lst_nxt = lst_r;
    sp_nxt = sp_r;
    w_nxt = w_r;
    cnt_nxt = cnt_r;
    head_nxt = head_r;
    i_nxt = i_r;
    k_nxt = k_r;
    post_nxt = post_r;
    hit_nxt = hit_r;
    t_nxt = t_r;
    mem_we = 1'b0;
    strobe_nxt = 1'b0;
    vv_nxt = '0;
    rw_nxt = '0;
    et_nxt = ecnt_r;
    dd_nxt = '0;
    st_nxt = 1'b0;
    la_nxt = 1'b0;
    e_idx = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_mode == MODE_SET || in_mode == MODE_DEL || in_mode == MODE_READ) begin
            if (!in_ok) begin
              strobe_nxt = 1'b1;
              st_nxt = 1'b1;
              la_nxt = 1'b1;
            end else if (in_mode == MODE_READ) begin
              hit_nxt = exists;
              t_nxt = ti;
              state_nxt = ST_RD;
            end else begin
              strobe_nxt = 1'b1;
              la_nxt = 1'b1;
              dd_nxt = deg_r[ti];
              if (in_mode == MODE_SET && wst != '0) begin
                mem_we = 1'b1;
                vld_nxt[fi][ti] = 1'b1;
                rw_nxt = WGT_W'(wst);
                if (!exists) begin
                  ecnt_nxt = ecnt_r + ECNT_W'(1);
                  deg_nxt[ti] = deg_r[ti] + DEG_W'(1);
                  et_nxt = ecnt_r + ECNT_W'(1);
                  dd_nxt = deg_r[ti] + DEG_W'(1);
                end
              end else if (exists) begin
                vld_nxt[fi][ti] = 1'b0;
                ecnt_nxt = ecnt_r - ECNT_W'(1);
                deg_nxt[ti] = deg_r[ti] - DEG_W'(1);
                et_nxt = ecnt_r - ECNT_W'(1);
                dd_nxt = deg_r[ti] - DEG_W'(1);
              end
            end
          end else if ((in_mode == MODE_DFS || in_mode == MODE_BFS) && !from_ok) begin
            strobe_nxt = 1'b1;
            st_nxt = 1'b1;
            la_nxt = 1'b1;
          end else if (in_mode == MODE_DFS || in_mode == MODE_BFS) begin
            vis_nxt = '0;
            vis_nxt[fi] = 1'b1;
            lst_nxt[0] = in_from_vertex;
            stk_nxt[0] = in_from_vertex;
            cnt_nxt = CW'(1);
            sp_nxt = CW'(1);
            head_nxt = '0;
            w_nxt = '0;
            post_nxt = 1'b0;
            state_nxt = (in_mode == MODE_DFS) ? ST_DFS : ST_BFS;
          end else if (in_mode == MODE_TOPO) begin
            vis_nxt = '0;
            cnt_nxt = '0;
            i_nxt = '0;
            post_nxt = 1'b1;
            state_nxt = ST_TNEXT;
          end
        end
      end
      ST_RD: begin
        strobe_nxt = 1'b1;
        la_nxt = 1'b1;
        rw_nxt = hit_r ? WGT_W'($signed(rdata_r)) : '0;
        dd_nxt = deg_r[t_r];
        state_nxt = ST_IDLE;
      end
      ST_DFS: begin
        if (w_lt) begin
          if (vld_r[vi][wi] && !vis_r[wi]) begin
            vis_nxt[wi] = 1'b1;
            cur_nxt[top_idx] = w_r + CW'(1);
            stk_nxt[sp_r[IW-1:0]] = VTX_W'(w_r);
            sp_nxt = sp_r + CW'(1);
            w_nxt = '0;
            if (!post_r) begin
              lst_nxt[cnt_r[IW-1:0]] = VTX_W'(w_r);
              cnt_nxt = cnt_r + CW'(1);
            end
          end else begin
            w_nxt = w_r + CW'(1);
          end
        end else begin
          sp_nxt = sp_m1;
          if (post_r) begin
            lst_nxt[cnt_r[IW-1:0]] = v_top;
            cnt_nxt = cnt_r + CW'(1);
          end
          if (sp_r == CW'(1)) begin
            k_nxt = '0;
            if (post_r) begin
              i_nxt = i_r + CW'(1);
              state_nxt = ST_TNEXT;
            end else begin
              state_nxt = ST_EMIT;
            end
          end else begin
            w_nxt = cur_r[sp_m2[IW-1:0]];
          end
        end
      end
      ST_BFS: begin
        if (w_lt) begin
          if (vld_r[bi][wi] && !vis_r[wi]) begin
            vis_nxt[wi] = 1'b1;
            lst_nxt[cnt_r[IW-1:0]] = VTX_W'(w_r);
            cnt_nxt = cnt_r + CW'(1);
          end
          w_nxt = w_r + CW'(1);
        end else begin
          head_nxt = head_r + CW'(1);
          w_nxt = '0;
          if (head_r + CW'(1) == cnt_r) begin
            k_nxt = '0;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_TNEXT: begin
        if (i_r == n_cnt) begin
          k_nxt = '0;
          state_nxt = ST_EMIT;
        end else if (vis_r[i_r[IW-1:0]]) begin
          i_nxt = i_r + CW'(1);
        end else begin
          vis_nxt[i_r[IW-1:0]] = 1'b1;
          stk_nxt[0] = VTX_W'(i_r);
          sp_nxt = CW'(1);
          w_nxt = '0;
          state_nxt = ST_DFS;
        end
      end
      ST_EMIT: begin
        // The topological listing is the postorder read back to front.
        e_idx = post_r ? (cnt_r - CW'(1) - k_r) : k_r;
        strobe_nxt = 1'b1;
        vv_nxt = lst_r[e_idx[IW-1:0]];
        la_nxt = (k_r == cnt_r - CW'(1));
        k_nxt = k_r + CW'(1);
        if (k_r == cnt_r - CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[fi][ti] <= wst;
    end
    rdata_r <= mem_r[fi][ti];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cfg_r <= CFG_RESET;
      ecnt_r <= '0;
      vis_r <= '0;
      strobe_r <= 1'b0;
      for (int j = 0; j < VCAP; j++) begin
        vld_r[j] <= '0;
        deg_r[j] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      ecnt_r <= ecnt_nxt;
      vis_r <= vis_nxt;
      strobe_r <= strobe_nxt;
      vld_r <= vld_nxt;
      deg_r <= deg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stk_r <= stk_nxt;
    cur_r <= cur_nxt;
    lst_r <= lst_nxt;
    sp_r <= sp_nxt;
    w_r <= w_nxt;
    cnt_r <= cnt_nxt;
    head_r <= head_nxt;
    i_r <= i_nxt;
    k_r <= k_nxt;
    post_r <= post_nxt;
    hit_r <= hit_nxt;
    t_r <= t_nxt;
    vv_r <= vv_nxt;
    rw_r <= rw_nxt;
    et_r <= et_nxt;
    dd_r <= dd_nxt;
    st_r <= st_nxt;
    la_r <= la_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;
  assign out_visited_vertex = vv_r;
  assign out_read_weight = rw_r;
  assign out_edge_total = et_r;
  assign out_dest_in_degree = dd_r;
  assign out_status = st_r;
  assign out_last = la_r;

  // A walk sends its vertex words back to back until the last one.
  a_walk_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("walk words not contiguous");

  a_busy_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy)
    else $error("idle in the middle of a walk");

  a_edge_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_mode == MODE_SET || in_mode == MODE_DEL) |=> out_strobe && out_last)
    else $error("edge update gave no single word");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_edge_total <= ECNT_W'(VCAP * VCAP))
    else $error("edge total out of range");

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the matrix graph traversal engine.
`default_nettype none
module tb_top;
  import mgte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [VTX_W-1:0]        src;
    logic [VTX_W-1:0]        dst;
    logic signed [WGT_W-1:0] wgt;
  } graph_cmd_t;

  typedef struct packed {
    logic [VTX_W-1:0]        vtx;
    logic signed [WGT_W-1:0] wgt;
    logic [ECNT_W-1:0]       total;
    logic [DEG_W-1:0]        deg;
    logic                    err;
    logic                    last;
  } graph_word_t;

  logic clk, rst_n, cfg_we, busy;
  logic start = 1'b0;
  logic [MODE_W-1:0] in_mode = '0;
  logic [VTX_W-1:0] in_from_vertex = '0;
  logic [VTX_W-1:0] in_to_vertex = '0;
  logic signed [WGT_W-1:0] in_edge_weight = '0;
  logic [CFG_W-1:0] cfg_wdata;
  logic out_strobe, out_status, out_last;
  logic [VTX_W-1:0] out_visited_vertex;
  logic signed [WGT_W-1:0] out_read_weight;
  logic [ECNT_W-1:0] out_edge_total;
  logic [DEG_W-1:0] out_dest_in_degree;

  matrix_graph_traversal_engine dut (
    .clk, .rst_n, .start, .busy, .in_mode, .in_from_vertex, .in_to_vertex,
    .in_edge_weight, .out_strobe, .out_visited_vertex, .out_read_weight,
    .out_edge_total, .out_dest_in_degree, .out_status, .out_last,
    .cfg_we, .cfg_wdata
  );

  // Shadow copy of the graph.
  logic signed [WGT_W-1:0] adj [16][16];
  int unsigned indeg [16];
  int unsigned n_edges;
  logic [CFG_W-1:0] vcount;
  bit seen [16];
  int unsigned order [$];

  graph_cmd_t  pending_cmds [$];
  graph_word_t expected_words [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct;
  bit stim_done;

  function automatic int unsigned live_vertices();
    if (vcount < 1) return 1;
    if (vcount > 16) return 16;
    return int'(vcount);
  endfunction

  function automatic void push_word(int unsigned v, logic signed [WGT_W-1:0] w,
                                    int unsigned d, bit err, bit lst);
    graph_word_t r;
    r.vtx = VTX_W'(v); r.wgt = w; r.total = ECNT_W'(n_edges); r.deg = DEG_W'(d);
    r.err = err; r.last = lst;
    expected_words.push_back(r);
  endfunction

  function automatic void depth_walk(int unsigned s, int unsigned n, bit post);
    int unsigned stk [16];
    int unsigned cur [16];
    int unsigned sp, v, w;
    seen[s] = 1;
    if (!post) order.push_back(s);
    stk[0] = s; cur[0] = 0; sp = 1;
    while (sp > 0) begin
      v = stk[sp-1];
      w = cur[sp-1];
      while (w < n && (adj[v][w] == 0 || seen[w])) w++;
      if (w < n && sp < 16) begin
        cur[sp-1] = w + 1;
        seen[w] = 1;
        if (!post) order.push_back(w);
        stk[sp] = w; cur[sp] = 0; sp++;
      end else begin
        sp--;
        if (post) order.push_back(v);
      end
    end
  endfunction

  function automatic void predict_graph_op(graph_cmd_t c);
    int unsigned n, f, t, head, v;
    int unsigned fifo [$];
    n = live_vertices();
    f = c.src;
    t = c.dst;
    if (c.mode > MODE_TOPO) return;
    if (c.mode <= MODE_READ) begin
      if (f >= n || t >= n) begin
        push_word(0, 0, 0, 1, 1);
        return;
      end
      if (c.mode == MODE_SET && c.wgt != 0) begin
        if (adj[f][t] == 0) begin
          n_edges++;
          indeg[t]++;
        end
        adj[f][t] = c.wgt;
      end else if (c.mode != MODE_READ && adj[f][t] != 0) begin
        // A zero-weight set behaves as a delete.
        n_edges--;
        indeg[t]--;
        adj[f][t] = 0;
      end
      push_word(0, adj[f][t], indeg[t], 0, 1);
      return;
    end
    if (c.mode != MODE_TOPO && f >= n) begin
      push_word(0, 0, 0, 1, 1);
      return;
    end
    foreach (seen[i]) seen[i] = 0;
    order.delete();
    if (c.mode == MODE_DFS) depth_walk(f, n, 0);
    else if (c.mode == MODE_BFS) begin
      seen[f] = 1;
      fifo.push_back(f);
      head = 0;
      while (head < fifo.size()) begin
        v = fifo[head++];
        order.push_back(v);
        for (int w = 0; w < n; w++)
          if (adj[v][w] != 0 && !seen[w] && fifo.size() < 16) begin
            seen[w] = 1;
            fifo.push_back(w);
          end
      end
    end else begin
      for (int i = 0; i < n; i++) if (!seen[i]) depth_walk(i, n, 1);
      order.reverse();
    end
    foreach (order[i]) push_word(order[i], 0, 0, 0, i == order.size() - 1);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
             cycle_count);
    fail_count++;
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Driver: the predictor runs when a word is taken, so state stays in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
    end else if (start && !busy) begin
      predict_graph_op({in_mode, in_from_vertex, in_to_vertex, in_edge_weight});
      if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
        {in_mode, in_from_vertex, in_to_vertex, in_edge_weight} <= pending_cmds.pop_front();
      end else begin
        start <= 0;
      end
    end else if (!start && pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
      {in_mode, in_from_vertex, in_to_vertex, in_edge_weight} <= pending_cmds.pop_front();
      start <= 1;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    graph_word_t e;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_strobe) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, vertex", out_visited_vertex, -1);
      end else begin
        e = expected_words.pop_front();
        if (out_visited_vertex !== e.vtx)
          report_mismatch("visited_vertex", out_visited_vertex, e.vtx);
        if (out_read_weight !== e.wgt) report_mismatch("read_weight", out_read_weight, e.wgt);
        if (out_edge_total !== e.total)
          report_mismatch("edge_total", out_edge_total, e.total);
        if (out_dest_in_degree !== e.deg)
          report_mismatch("dest_in_degree", out_dest_in_degree, e.deg);
        if (out_status !== e.err) report_mismatch("status", out_status, e.err);
        if (out_last !== e.last) report_mismatch("last", out_last, e.last);
      end
    end
    if (cycle_count > 1500000) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic graph_cmd_t mk(int m, int f, int t, int w);
    graph_cmd_t c;
    c.mode = MODE_W'(m); c.src = VTX_W'(f); c.dst = VTX_W'(t); c.wgt = WGT_W'(w);
    return c;
  endfunction

  function automatic graph_cmd_t rand_cmd(int unsigned n);
    graph_cmd_t c;
    int unsigned r;
    r = $urandom_range(99);
    // Mostly in-range edge traffic, mixed with walks and a few unused modes.
    if (r < 50) c.mode = MODE_SET;
    else if (r < 60) c.mode = MODE_DEL;
    else if (r < 68) c.mode = MODE_READ;
    else if (r < 78) c.mode = MODE_DFS;
    else if (r < 88) c.mode = MODE_BFS;
    else if (r < 96) c.mode = MODE_TOPO;
    else c.mode = MODE_W'($urandom_range(7, 6));
    c.src = VTX_W'(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n - 1));
    c.dst = VTX_W'(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n - 1));
    c.wgt = ($urandom_range(9) == 0) ? '0 : WGT_W'($urandom());
    return c;
  endfunction

  task automatic drain_and_idle();
    while (pending_cmds.size() > 0 || start || expected_words.size() > 0 || busy)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [CFG_W-1:0] v);
    cfg_wdata <= v;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    vcount = v;
    @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] cfg_list [6];
    int unsigned pct [4];
    cfg_list = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16};
    pct = '{0, 53, 21, 0};
    rst_n = 0; cfg_we = 0; cfg_wdata = 0;
    idle_pct = 0;
    vcount = CFG_RESET; n_edges = 0;
    foreach (adj[i, j]) adj[i][j] = 0;
    foreach (indeg[i]) indeg[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, a cycle, zero-weight set, out-of-range, unused modes.
    pending_cmds.push_back(mk(MODE_TOPO, 0, 0, 0));
    pending_cmds.push_back(mk(MODE_SET, 0, 15, 16'sh7fff));
    pending_cmds.push_back(mk(MODE_SET, 15, 0, -32768));
    pending_cmds.push_back(mk(MODE_SET, 0, 1, -1));
    pending_cmds.push_back(mk(MODE_SET, 0, 1, 5));
    pending_cmds.push_back(mk(MODE_SET, 1, 2, 1));
    pending_cmds.push_back(mk(MODE_SET, 2, 0, 1));
    pending_cmds.push_back(mk(MODE_READ, 0, 15, 0));
    pending_cmds.push_back(mk(MODE_DFS, 0, 0, 0));
    pending_cmds.push_back(mk(MODE_BFS, 15, 0, 0));
    pending_cmds.push_back(mk(MODE_TOPO, 9, 9, 0));
    pending_cmds.push_back(mk(MODE_SET, 1, 2, 0));
    pending_cmds.push_back(mk(MODE_DEL, 3, 4, 0));
    pending_cmds.push_back(mk(MODE_DEL, 15, 0, 0));
    pending_cmds.push_back(mk(6, 1, 1, 1));
    pending_cmds.push_back(mk(7, 15, 15, -1));
    pending_cmds.push_back(mk(MODE_READ, 15, 0, 0));
    drain_and_idle();
    write_vertex_count(5'd4);
    pending_cmds.push_back(mk(MODE_SET, 4, 0, 3));
    pending_cmds.push_back(mk(MODE_DFS, 15, 0, 0));
    pending_cmds.push_back(mk(MODE_READ, 0, 15, 0));
    pending_cmds.push_back(mk(MODE_TOPO, 0, 0, 0));
    drain_and_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_vertex_count(cfg_list[ph]);
      idle_pct = pct[ph % 4];
      for (int k = 0; k < 50; k++) pending_cmds.push_back(rand_cmd(live_vertices()));
      drain_and_idle();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
